[sv/sfnv_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse FNV-1a 64 hash package
// Shared constants, the front-to-back queue entry and the hash arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package sfnv_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int LG_W = $clog2(LENGTH_BITS + 1);
	localparam int LEN_SHIFT = 5;
	localparam int MIX_W = LENGTH_BITS - LEN_SHIFT;
	localparam int VALUE_W = 21;
	localparam int HASH_W = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_PER_STRIDE = 8;

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [HASH_W-1:0] ALL_ONES_SUB = 64'hfffffffffffffffe;

	typedef struct packed {
		logic start;
		logic fold;
		logic last;
		logic [VALUE_W-1:0] value;
		logic [MIX_W-1:0] mix;
	} entry_t;

	// The FNV prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
	function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] h);
		fnv_mul = h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8) + (h << 40);
	endfunction

	function automatic logic [HASH_W-1:0] fnv_finish(input logic [HASH_W-1:0] h,
			input logic [MIX_W-1:0] mix);
		logic [HASH_W-1:0] r;
		r = h ^ {{(HASH_W - MIX_W){1'b0}}, mix};
		if (r == '1) begin
			r = ALL_ONES_SUB;
		end
		fnv_finish = r;
	endfunction

endpackage

`default_nettype wire

[sv/sfnv_in_if.sv]
// ----------------------------------------------------------------------------
// Sparse FNV-1a 64 hash request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfnv_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [31:0] length;
	logic [sfnv_pkg::VALUE_W-1:0] value;

	modport source (output valid, output req_type, output length, output value, input ready);
	modport sink (input valid, input req_type, input length, input value, output ready);
endinterface

`default_nettype wire

[sv/sfnv_out_if.sv]
// ----------------------------------------------------------------------------
// Sparse FNV-1a 64 hash result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfnv_out_if;
	logic valid;
	logic ready;
	logic signed [sfnv_pkg::HASH_W-1:0] hash;

	modport source (output valid, output hash, input ready);
	modport sink (input valid, input hash, output ready);
endinterface

`default_nettype wire

[sv/sfnv_front.sv]
// ----------------------------------------------------------------------------
// Sparse FNV-1a 64 hash front end
// Accepts items, tracks the open message and stride, and queues only the
// starts and the elements that fold into the hash or close the message.
// ----------------------------------------------------------------------------
`default_nettype none

module sfnv_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	sfnv_in_if.sink              req,
	output sfnv_pkg::entry_t     push_data,
	output logic                 push_valid,
	input  wire logic            push_ready
);

	logic [63:0] len_full;
	logic [sfnv_pkg::LENGTH_BITS-1:0] len;
	logic [sfnv_pkg::LG_W-1:0] lg_new;
	logic [sfnv_pkg::LENGTH_BITS-1:0] pos_mask;
	logic [sfnv_pkg::LENGTH_BITS:0] cnt_nxt;
	logic fold;
	logic last;
	logic acc;

	logic [sfnv_pkg::LENGTH_BITS-1:0] msg_len_q;
	logic [sfnv_pkg::LENGTH_BITS-1:0] count_q;
	logic [sfnv_pkg::LG_W-1:0] lg_q;
	logic active_q;

	assign req.ready = push_ready;
	assign acc = req.valid && push_ready;

	assign len_full = {32'd0, req.length};
	assign len = len_full[sfnv_pkg::LENGTH_BITS-1:0];

	always_comb begin
		lg_new = sfnv_pkg::LG_W'(1);
		for (int i = sfnv_pkg::LENGTH_BITS - 1; i >= 1; i--) begin
			if ((len >> i) <= sfnv_pkg::LENGTH_BITS'(sfnv_pkg::MAX_PER_STRIDE)) begin
				lg_new = sfnv_pkg::LG_W'(i);
			end
		end
	end

	assign pos_mask = (sfnv_pkg::LENGTH_BITS'(1) << lg_q) - sfnv_pkg::LENGTH_BITS'(1);
	assign fold = (count_q & pos_mask) == pos_mask;
	assign cnt_nxt = {1'b0, count_q} + {{sfnv_pkg::LENGTH_BITS{1'b0}}, 1'b1};
	assign last = cnt_nxt >= {1'b0, msg_len_q};

	always_comb begin
		push_valid = 1'b0;
		push_data.start = 1'b0;
		push_data.fold = fold;
		push_data.last = last;
		push_data.value = req.value;
		push_data.mix = msg_len_q[sfnv_pkg::LENGTH_BITS-1:sfnv_pkg::LEN_SHIFT];
		if (req.req_type == 1'b0) begin
			push_valid = req.valid;
			push_data.start = 1'b1;
			push_data.fold = 1'b0;
			push_data.last = len <= sfnv_pkg::LENGTH_BITS'(1);
			push_data.mix = len[sfnv_pkg::LENGTH_BITS-1:sfnv_pkg::LEN_SHIFT];
		end else begin
			push_valid = req.valid && active_q && (fold || last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q <= '0;
			count_q <= '0;
			lg_q <= sfnv_pkg::LG_W'(1);
			active_q <= 1'b0;
		end else if (acc) begin
			if (req.req_type == 1'b0) begin
				msg_len_q <= len;
				count_q <= '0;
				lg_q <= lg_new;
				active_q <= len > sfnv_pkg::LENGTH_BITS'(1);
			end else if (active_q) begin
				count_q <= cnt_nxt[sfnv_pkg::LENGTH_BITS-1:0];
				if (last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

[sv/sfnv_queue.sv]
// ----------------------------------------------------------------------------
// Sparse FNV-1a 64 hash queue
// Short register queue that decouples the front end from the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sfnv_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfnv_pkg::entry_t  push_data,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output sfnv_pkg::entry_t       pop_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready
);

	sfnv_pkg::entry_t entries_q [sfnv_pkg::QUEUE_DEPTH];
	logic [sfnv_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sfnv_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sfnv_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = count_q != sfnv_pkg::QCNT_W'(sfnv_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = entries_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + sfnv_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + sfnv_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + sfnv_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - sfnv_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[sv/sfnv_back.sv]
// ----------------------------------------------------------------------------
// Sparse FNV-1a 64 hash engine
// Folds queued elements into the hash and registers the finished result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfnv_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfnv_pkg::entry_t  pop_data,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	sfnv_out_if.source             rsp
);

	logic [sfnv_pkg::HASH_W-1:0] hash_q;
	logic [sfnv_pkg::MIX_W-1:0] mix_q;
	logic [sfnv_pkg::HASH_W-1:0] hash_out_q;
	logic out_valid_q;
	logic [sfnv_pkg::HASH_W-1:0] h_new;
	logic [sfnv_pkg::MIX_W-1:0] mix_sel;
	logic do_pop;

	assign pop_ready = !pop_data.last || !out_valid_q || rsp.ready;
	assign do_pop = pop_valid && pop_ready;
	assign rsp.valid = out_valid_q;
	assign rsp.hash = $signed(hash_out_q);

	always_comb begin
		if (pop_data.start) begin
			h_new = sfnv_pkg::FNV_BASIS;
			mix_sel = pop_data.mix;
		end else begin
			mix_sel = mix_q;
			if (pop_data.fold) begin
				h_new = sfnv_pkg::fnv_mul(hash_q ^ {{(sfnv_pkg::HASH_W - sfnv_pkg::VALUE_W){1'b0}},
					pop_data.value});
			end else begin
				h_new = hash_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && pop_data.last) begin
			hash_out_q <= sfnv_pkg::fnv_finish(h_new, mix_sel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= sfnv_pkg::FNV_BASIS;
			mix_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				hash_q <= h_new;
				if (pop_data.start) begin
					mix_q <= pop_data.mix;
				end
			end
			if (do_pop && pop_data.last) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[sv/sparse_fnv1a_64_hash_top.sv]
// ----------------------------------------------------------------------------
// Sparse FNV-1a 64 hash top level
// A message's hash is registered once its closing item passes the queue.
// Throughput: one item and one fold per cycle, unless the output stalls.
// A four-entry queue between front end and hash engine absorbs output stalls.
// Reset: arst_n clears all control state at once; no message is open after it.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_fnv1a_64_hash_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sfnv_in_if.sink    req,
	sfnv_out_if.source rsp
);

	sfnv_pkg::entry_t push_data;
	logic push_valid;
	logic push_ready;
	sfnv_pkg::entry_t pop_data;
	logic pop_valid;
	logic pop_ready;

	sfnv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	sfnv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	sfnv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
